>>> rtl/pgtm_pkg.sv
// ----------------------------------------------------------------------------
// pgtm_pkg: shared types and constants of the page table mapper
// Holds entry masks, status and action codes, sequencer states and the
// structs passed between the sequencer and the entry update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pgtm_pkg;

   // Pool geometry defaults
   localparam int POOL_PAGES_DEFAULT      = 16;
   localparam int FIRST_FREE_PAGE_DEFAULT = 4;
   localparam int ENTRIES_PER_TABLE       = 512;
   localparam int SLOT_W                  = 9;
   // Page numbers up to the largest pool plus room for the exhaustion check
   localparam int PAGE_NUM_W              = 9;

   localparam int ENTRY_W   = 64;
   localparam int FRAME_W   = 40;
   localparam int VA_IDX_W  = 36;
   localparam int DIR_FLAG_W = 6;

   localparam logic [ENTRY_W-1:0] KEEP_MASK = 64'hFFF0_0000_0000_0FFF;

   localparam logic [1:0] LAST_LEVEL = 2'd3;

   localparam logic ACTION_MAP  = 1'b0;
   localparam logic ACTION_LOAD = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_OUTSIDE   = 2'd2,
      STATUS_HALTED    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_ZERO,
      ST_WRITE,
      ST_DONE
   } state_type;

   // Request to the entry update unit
   typedef struct packed {
      logic [ENTRY_W-1:0]    entry;
      logic                  leaf;
      logic [PAGE_NUM_W-1:0] take;
      logic [FRAME_W-1:0]    base;
      logic [ENTRY_W-1:0]    flags;
      logic [FRAME_W-1:0]    pa_frame;
   } unit_in_type;

   // Answer of the entry update unit
   typedef struct packed {
      logic                  present;
      logic                  exhausted;
      logic                  outside;
      logic [ENTRY_W-1:0]    new_entry;
      logic [PAGE_NUM_W-1:0] child;
   } unit_out_type;

   // Replace the address field of an entry with a frame number
   function automatic logic [ENTRY_W-1:0] put_frame(input logic [ENTRY_W-1:0] entry,
                                                    input logic [FRAME_W-1:0] frame);
      put_frame = (entry & KEEP_MASK) | {12'b0, frame, 12'b0};
   endfunction

endpackage

`default_nettype wire

>>> rtl/pgtm_channels.sv
// ----------------------------------------------------------------------------
// pgtm_channels: valid/ready channels of the page table mapper
// Request, response and register write channels, each with source and
// sink views.
// ----------------------------------------------------------------------------
`default_nettype none

interface pgtm_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [47:0] virt_address;
   logic [51:0] phys_address;
   logic [63:0] map_flags;
   logic [3:0]  load_page;
   logic [8:0]  load_slot;
   logic [63:0] load_value;

   modport source (output valid, action, virt_address, phys_address, map_flags,
                   load_page, load_slot, load_value, input ready);
   modport sink   (input valid, action, virt_address, phys_address, map_flags,
                   load_page, load_slot, load_value, output ready);
endinterface

interface pgtm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [1:0] tables_added;
   logic       flush_needed;

   modport source (output valid, status, tables_added, flush_needed, input ready);
   modport sink   (input valid, status, tables_added, flush_needed, output ready);
endinterface

interface pgtm_csr_if;
   logic        valid;
   logic        ready;
   logic [39:0] pool_base_frame;

   modport source (output valid, pool_base_frame, input ready);
   modport sink   (input valid, pool_base_frame, output ready);
endinterface

`default_nettype wire

>>> rtl/four_level_page_table_mapper_core.sv
// ----------------------------------------------------------------------------
// four_level_page_table_mapper_core: four-level page table mapper
// Walks and extends a four-level page table held in an on-chip pool of
// table pages, allocating and zeroing pages on demand.
//
//   channel  dir  transfer carries
//   -------  ---  ------------------------------------------------------
//   req_chan in   action, virt/phys address, flags, raw load target/word
//   rsp_chan out  status, tables_added, flush_needed
//   csr_chan in   pool_base_frame
//
// A map passes through the read, evaluate and write states at each
// level and then hands off the response; each table page allocated is
// first zeroed entry by entry through the single port of the table memory.
// A raw load or a request while halted goes straight to the hand-off.
// After reset the table memory is cleared entry by entry; requests
// wait, register writes are taken. One request at a time; the next is
// accepted while a response still waits for rsp_chan.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_mapper_core #(
   parameter int POOL_PAGES      = pgtm_pkg::POOL_PAGES_DEFAULT,
   parameter int FIRST_FREE_PAGE = pgtm_pkg::FIRST_FREE_PAGE_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pgtm_req_if.sink   req_chan,
   pgtm_rsp_if.source rsp_chan,
   pgtm_csr_if.sink   csr_chan
);

   localparam int PW        = $clog2(POOL_PAGES);
   localparam int NFW       = PW + 1;
   localparam int AW        = PW + pgtm_pkg::SLOT_W;
   localparam int MEM_DEPTH = POOL_PAGES * pgtm_pkg::ENTRIES_PER_TABLE;
   localparam int SW        = pgtm_pkg::SLOT_W;
   localparam int NUMW      = pgtm_pkg::PAGE_NUM_W;

   // Table memory
   logic [pgtm_pkg::ENTRY_W-1:0] table_mem [MEM_DEPTH];

   pgtm_pkg::state_type          state_ff, state_in;
   logic [1:0]                   level_ff, level_in;
   logic [PW-1:0]                page_ff, page_in;
   logic [PW-1:0]                child_ff, child_in;
   logic [NFW-1:0]               next_free_ff, next_free_in;
   logic                         halted_ff, halted_in;
   logic [pgtm_pkg::FRAME_W-1:0] base_ff, base_in;
   logic [pgtm_pkg::VA_IDX_W-1:0] va_ff, va_in;
   logic [pgtm_pkg::FRAME_W-1:0] pa_frame_ff, pa_frame_in;
   logic [pgtm_pkg::ENTRY_W-1:0] flags_ff, flags_in;
   logic [pgtm_pkg::ENTRY_W-1:0] entry_ff, entry_in;
   logic [1:0]                   added_ff, added_in;
   pgtm_pkg::status_type         status_ff, status_in;
   logic                         flush_ff, flush_in;
   logic [AW-1:0]                sweep_ff, sweep_in;
   logic [pgtm_pkg::ENTRY_W-1:0] rd_data_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   pgtm_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [1:0]                   rsp_added_ff, rsp_added_in;
   logic                         rsp_flush_ff, rsp_flush_in;

   logic                         mem_we;
   logic [AW-1:0]                mem_addr;
   logic [pgtm_pkg::ENTRY_W-1:0] mem_wdata;
   logic [SW-1:0]                level_idx;
   logic                         req_xfer;
   logic                         load_in_pool;
   logic                         rsp_free;

   pgtm_pkg::unit_in_type        unit_in;
   pgtm_pkg::unit_out_type       unit_out;

   // Entry update unit
   pgtm_entry_unit #(
      .POOL_PAGES (POOL_PAGES)
   ) u_entry_unit (
      .unit_in  (unit_in),
      .unit_out (unit_out)
   );

   always_comb begin
      unit_in.entry    = rd_data_ff;
      unit_in.leaf     = (level_ff == pgtm_pkg::LAST_LEVEL);
      unit_in.take     = NUMW'(next_free_ff);
      unit_in.base     = base_ff;
      unit_in.flags    = flags_ff;
      unit_in.pa_frame = pa_frame_ff;
   end

   // Select the table index of the current level
   always_comb begin
      case (level_ff)
         2'd0:    level_idx = va_ff[35:27];
         2'd1:    level_idx = va_ff[26:18];
         2'd2:    level_idx = va_ff[17:9];
         default: level_idx = va_ff[8:0];
      endcase
   end

   // Handshakes
   assign req_chan.ready = (state_ff == pgtm_pkg::ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign load_in_pool   = (NUMW'(req_chan.load_page) < NUMW'(POOL_PAGES));
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.tables_added = rsp_added_ff;
   assign rsp_chan.flush_needed = rsp_flush_ff;

   // Sequencer: next state, memory access and response
   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      page_in       = page_ff;
      child_in      = child_ff;
      next_free_in  = next_free_ff;
      halted_in     = halted_ff;
      base_in       = base_ff;
      va_in         = va_ff;
      pa_frame_in   = pa_frame_ff;
      flags_in      = flags_ff;
      entry_in      = entry_ff;
      added_in      = added_ff;
      status_in     = status_ff;
      flush_in      = flush_ff;
      sweep_in      = sweep_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_added_in  = rsp_added_ff;
      rsp_flush_in  = rsp_flush_ff;
      mem_we        = 1'b0;
      mem_addr      = {page_ff, level_idx};
      mem_wdata     = entry_ff;

      if (csr_chan.valid) begin
         base_in = csr_chan.pool_base_frame;
      end

      case (state_ff)
         pgtm_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = sweep_ff;
            mem_wdata = '0;
            sweep_in  = sweep_ff + AW'(1);
            if (sweep_ff == AW'(MEM_DEPTH - 1)) begin
               state_in = pgtm_pkg::ST_IDLE;
            end
         end
         pgtm_pkg::ST_IDLE: begin
            if (req_xfer) begin
               added_in = 2'd0;
               flush_in = 1'b0;
               if (halted_ff) begin
                  status_in = pgtm_pkg::STATUS_HALTED;
                  state_in  = pgtm_pkg::ST_DONE;
               end else if (req_chan.action == pgtm_pkg::ACTION_LOAD) begin
                  mem_we    = load_in_pool;
                  mem_addr  = {PW'(req_chan.load_page), req_chan.load_slot};
                  mem_wdata = req_chan.load_value;
                  status_in = pgtm_pkg::STATUS_DONE;
                  state_in  = pgtm_pkg::ST_DONE;
               end else begin
                  va_in       = req_chan.virt_address[47:12];
                  pa_frame_in = req_chan.phys_address[51:12];
                  flags_in    = req_chan.map_flags;
                  level_in    = 2'd0;
                  page_in     = '0;
                  state_in    = pgtm_pkg::ST_READ;
               end
            end
         end
         pgtm_pkg::ST_READ: begin
            state_in = pgtm_pkg::ST_EVAL;
         end
         pgtm_pkg::ST_EVAL: begin
            entry_in = unit_out.new_entry;
            child_in = PW'(unit_out.child);
            if (level_ff == pgtm_pkg::LAST_LEVEL) begin
               state_in = pgtm_pkg::ST_WRITE;
            end else if (unit_out.exhausted) begin
               halted_in = 1'b1;
               status_in = pgtm_pkg::STATUS_EXHAUSTED;
               state_in  = pgtm_pkg::ST_DONE;
            end else if (unit_out.outside) begin
               status_in = pgtm_pkg::STATUS_OUTSIDE;
               state_in  = pgtm_pkg::ST_DONE;
            end else if (!unit_out.present) begin
               next_free_in = next_free_ff + NFW'(1);
               added_in     = added_ff + 2'd1;
               sweep_in     = '0;
               state_in     = pgtm_pkg::ST_ZERO;
            end else begin
               state_in = pgtm_pkg::ST_WRITE;
            end
         end
         pgtm_pkg::ST_ZERO: begin
            // Zero the new table before linking it
            mem_we    = 1'b1;
            mem_addr  = {child_ff, sweep_ff[SW-1:0]};
            mem_wdata = '0;
            sweep_in  = sweep_ff + AW'(1);
            if (sweep_ff[SW-1:0] == SW'(pgtm_pkg::ENTRIES_PER_TABLE - 1)) begin
               state_in = pgtm_pkg::ST_WRITE;
            end
         end
         pgtm_pkg::ST_WRITE: begin
            mem_we = 1'b1;
            if (level_ff == pgtm_pkg::LAST_LEVEL) begin
               status_in = pgtm_pkg::STATUS_DONE;
               flush_in  = 1'b1;
               state_in  = pgtm_pkg::ST_DONE;
            end else begin
               page_in  = child_ff;
               level_in = level_ff + 2'd1;
               state_in = pgtm_pkg::ST_READ;
            end
         end
         pgtm_pkg::ST_DONE: begin
            // Hand the result to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_added_in  = added_ff;
               rsp_flush_in  = flush_ff;
               state_in      = pgtm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pgtm_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pgtm_pkg::ST_CLEAR;
         sweep_ff     <= '0;
         next_free_ff <= NFW'(FIRST_FREE_PAGE);
         halted_ff    <= 1'b0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         next_free_ff <= next_free_in;
         halted_ff    <= halted_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      level_ff      <= level_in;
      page_ff       <= page_in;
      child_ff      <= child_in;
      va_ff         <= va_in;
      pa_frame_ff   <= pa_frame_in;
      flags_ff      <= flags_in;
      entry_ff      <= entry_in;
      added_ff      <= added_in;
      status_ff     <= status_in;
      flush_ff      <= flush_in;
      rsp_status_ff <= rsp_status_in;
      rsp_added_ff  <= rsp_added_in;
      rsp_flush_ff  <= rsp_flush_in;
   end

   // Single-port table memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[mem_addr];
   end

   // A request taken while halted answers halted
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && halted_ff |=>
         state_ff == pgtm_pkg::ST_DONE && status_ff == pgtm_pkg::STATUS_HALTED)
      else $error("halted request did not answer halted");

   // Halt is set only by an exhausted pool
   assert property (@(posedge clock) disable iff (reset)
      $rose(halted_ff) |->
         state_ff == pgtm_pkg::ST_DONE && status_ff == pgtm_pkg::STATUS_EXHAUSTED)
      else $error("halt set without pool exhaustion");

   // Never zero the root table
   assert property (@(posedge clock) disable iff (reset)
      state_ff == pgtm_pkg::ST_ZERO |-> child_ff != '0)
      else $error("zeroing the root table");

   // Leaf write ends the walk with a flush
   assert property (@(posedge clock) disable iff (reset)
      state_ff == pgtm_pkg::ST_WRITE && level_ff == pgtm_pkg::LAST_LEVEL |=>
         state_ff == pgtm_pkg::ST_DONE && flush_ff)
      else $error("leaf write without flush");

   // A flush is only reported for a completed map
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flush_ff |-> rsp_status_ff == pgtm_pkg::STATUS_DONE)
      else $error("flush reported on a failed map");

endmodule

`default_nettype wire

>>> rtl/pgtm_entry_unit.sv
// ----------------------------------------------------------------------------
// pgtm_entry_unit: shared entry update unit
// Decodes one table entry and builds its new value for a directory walk,
// a table allocation or the leaf; one 40-bit adder serves both the frame
// of a new table and the pool-relative page of an existing one.
// ----------------------------------------------------------------------------
`default_nettype none

module pgtm_entry_unit #(
   parameter int POOL_PAGES = pgtm_pkg::POOL_PAGES_DEFAULT
) (
   input  pgtm_pkg::unit_in_type  unit_in,
   output pgtm_pkg::unit_out_type unit_out
);

   localparam int NUM_W = pgtm_pkg::PAGE_NUM_W + 1;

   logic                                present;
   logic                                alloc;
   logic [pgtm_pkg::FRAME_W-1:0]        add_a;
   logic [pgtm_pkg::FRAME_W-1:0]        add_b;
   logic [pgtm_pkg::FRAME_W-1:0]        sum;
   logic [pgtm_pkg::ENTRY_W-1:0]        dflags;
   logic [NUM_W-1:0]                    take_next;

   // Classify the entry
   assign present = unit_in.entry[0];
   assign alloc   = !unit_in.leaf && !present;
   assign dflags  = {{(pgtm_pkg::ENTRY_W-pgtm_pkg::DIR_FLAG_W){1'b0}},
                     unit_in.flags[pgtm_pkg::DIR_FLAG_W-1:0]};

   // Shared adder: base plus new page, or entry frame minus base
   always_comb begin
      if (alloc) begin
         add_a = unit_in.base;
         add_b = {{(pgtm_pkg::FRAME_W-pgtm_pkg::PAGE_NUM_W){1'b0}}, unit_in.take};
      end else begin
         add_a = unit_in.entry[51:12];
         add_b = ~unit_in.base;
      end
   end
   assign sum = add_a + add_b + {{(pgtm_pkg::FRAME_W-1){1'b0}}, !alloc};

   assign take_next = {1'b0, unit_in.take} + NUM_W'(1);

   // Build the new entry and the checks
   always_comb begin
      unit_out.present   = present;
      unit_out.exhausted = alloc && (take_next >= NUM_W'(POOL_PAGES));
      unit_out.outside   = !unit_in.leaf && present &&
                           (sum >= pgtm_pkg::FRAME_W'(POOL_PAGES));
      if (unit_in.leaf) begin
         unit_out.new_entry = pgtm_pkg::put_frame(unit_in.entry | unit_in.flags |
                                                  pgtm_pkg::ENTRY_W'(1), unit_in.pa_frame);
         unit_out.child     = unit_in.take;
      end else if (alloc) begin
         unit_out.new_entry = pgtm_pkg::put_frame(unit_in.entry | pgtm_pkg::ENTRY_W'(1),
                                                  sum) | dflags;
         unit_out.child     = unit_in.take;
      end else begin
         unit_out.new_entry = unit_in.entry | dflags;
         unit_out.child     = sum[pgtm_pkg::PAGE_NUM_W-1:0];
      end
   end

endmodule

`default_nettype wire

>>> tb/pgtm_checker.sv
// ----------------------------------------------------------------------------
// pgtm_checker: reply checker for the four-level page table mapper
// Watches the request, response and register channels. Keeps its own copy
// of the table pool, allocation pointer, halt flag and pool base frame.
// Predicts one reply per accepted request and compares each field of every
// accepted response against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module pgtm_checker #(
   parameter int POOL_PAGES      = pgtm_pkg::POOL_PAGES_DEFAULT,
   parameter int FIRST_FREE_PAGE = pgtm_pkg::FIRST_FREE_PAGE_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pgtm_req_if         req_mon,
   pgtm_rsp_if         rsp_mon,
   pgtm_csr_if         csr_mon,
   output int unsigned mismatches,
   output int unsigned outstanding
);
   import pgtm_pkg::*;

   localparam int          WORDS       = POOL_PAGES * ENTRIES_PER_TABLE;
   localparam int unsigned PRINT_LIMIT = 20;
   localparam logic [63:0] DIR_FLAGS   = 64'h3F;

   typedef struct packed {
      status_type status;
      logic [1:0] tables_added;
      logic       flush_needed;
   } map_reply_t;

   // Shadow state of the block
   logic [63:0]  pool_words [WORDS];
   int unsigned  next_free;
   bit           halted;
   logic [39:0]  base_frame;

   map_reply_t   expected_replies [$];
   int unsigned  replies_seen;

   // Count a failure; print only the first few
   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) begin
         $display("MISMATCH at reply %0d: %s", replies_seen, msg);
      end
      mismatches++;
   endtask

   function automatic logic [63:0] place_frame(input logic [63:0] word,
                                               input logic [39:0] frame);
      return (word & KEEP_MASK) | {12'b0, frame, 12'b0};
   endfunction

   // Apply one request to the shadow pool and return the reply it earns
   function automatic map_reply_t predict_reply(input logic        action,
                                                input logic [47:0] va,
                                                input logic [51:0] pa,
                                                input logic [63:0] flags,
                                                input logic [3:0]  lpage,
                                                input logic [8:0]  lslot,
                                                input logic [63:0] lvalue);
      map_reply_t  reply;
      logic [8:0]  level_idx [4];
      logic [63:0] word;
      logic [39:0] rel;
      int unsigned page, child, pos, lvl, k;
      reply.status       = STATUS_DONE;
      reply.tables_added = 2'd0;
      reply.flush_needed = 1'b0;
      if (halted) begin
         reply.status = STATUS_HALTED;
         return reply;
      end
      if (action == ACTION_LOAD) begin
         if (int'(lpage) < POOL_PAGES) begin
            pool_words[int'(lpage) * ENTRIES_PER_TABLE + int'(lslot)] = lvalue;
         end
         return reply;
      end
      level_idx[0] = va[47:39];
      level_idx[1] = va[38:30];
      level_idx[2] = va[29:21];
      level_idx[3] = va[20:12];
      page = 0;
      // Walk root, level 3 and level 2, allocating missing tables
      for (lvl = 0; lvl < 3; lvl++) begin
         pos  = page * ENTRIES_PER_TABLE + int'(level_idx[lvl]);
         word = pool_words[pos];
         if (!word[0]) begin
            if (next_free + 1 >= POOL_PAGES) begin
               halted       = 1'b1;
               reply.status = STATUS_EXHAUSTED;
               return reply;
            end
            child = next_free;
            next_free++;
            for (k = 0; k < ENTRIES_PER_TABLE; k++) begin
               pool_words[child * ENTRIES_PER_TABLE + k] = '0;
            end
            word = place_frame(word | 64'd1, base_frame + 40'(child));
            reply.tables_added = reply.tables_added + 2'd1;
         end else begin
            rel = word[51:12] - base_frame;
            if (rel >= 40'(POOL_PAGES)) begin
               reply.status = STATUS_OUTSIDE;
               return reply;
            end
            child = int'(rel[8:0]);
         end
         pool_words[pos] = word | (flags & DIR_FLAGS);
         page = child;
      end
      // Write the leaf entry
      pos = page * ENTRIES_PER_TABLE + int'(level_idx[3]);
      pool_words[pos] = place_frame(pool_words[pos] | 64'd1 | flags, pa[51:12]);
      reply.flush_needed = 1'b1;
      return reply;
   endfunction

   always @(posedge clock) begin : watch
      map_reply_t  want;
      int unsigned i;
      if (reset) begin
         for (i = 0; i < WORDS; i++) begin
            pool_words[i] = '0;
         end
         next_free  = FIRST_FREE_PAGE;
         halted     = 1'b0;
         base_frame = '0;
         expected_replies.delete();
      end else begin
         // Compare each response transfer with the oldest prediction
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("response with no request waiting");
            end else begin
               want = expected_replies.pop_front();
               if (rsp_mon.status !== want.status) begin
                  report_mismatch($sformatf("status expected %0d got %0d",
                                            want.status, rsp_mon.status));
               end
               if (rsp_mon.tables_added !== want.tables_added) begin
                  report_mismatch($sformatf("tables_added expected %0d got %0d",
                                            want.tables_added, rsp_mon.tables_added));
               end
               if (rsp_mon.flush_needed !== want.flush_needed) begin
                  report_mismatch($sformatf("flush_needed expected %0d got %0d",
                                            want.flush_needed, rsp_mon.flush_needed));
               end
            end
            replies_seen++;
         end
         // Track register writes
         if (csr_mon.valid === 1'b1 && csr_mon.ready === 1'b1) begin
            base_frame = csr_mon.pool_base_frame;
         end
         // Predict the reply of each request transfer
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            expected_replies.push_back(predict_reply(req_mon.action, req_mon.virt_address,
                                                     req_mon.phys_address, req_mon.map_flags,
                                                     req_mon.load_page, req_mon.load_slot,
                                                     req_mon.load_value));
         end
      end
      outstanding <= expected_replies.size();
   end

endmodule

`default_nettype wire

>>> tb/four_level_page_table_mapper_core_tb.sv
// ----------------------------------------------------------------------------
// four_level_page_table_mapper_core_tb: top of the page table mapper bench
// Drives map and raw load requests and pool base writes into the mapper,
// with random gaps on both channels, a long response hold-off and a pause
// of the request side. Builds table chains with raw loads so that most maps
// walk deep without allocating, breaks links to reach the outside-pool case,
// and ends by exhausting the pool and probing the halted state.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_mapper_core_tb;
   import pgtm_pkg::*;

   localparam int          POOL_PAGES      = POOL_PAGES_DEFAULT;
   localparam int          PHASES          = 6;
   localparam int unsigned ITEMS_PER_PHASE = 330;
   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int          HOLDOFF_CYCLES  = 400;
   localparam int unsigned MAX_GAP         = 40;
   localparam int          DRAIN_CYCLES    = 20;
   localparam logic [8:0]  FRESH_ROOT      = 9'h155;

   logic clock;
   logic reset;

   pgtm_req_if req_chan ();
   pgtm_rsp_if rsp_chan ();
   pgtm_csr_if csr_chan ();

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned cycle_count;
   int unsigned send_idle_pct;
   int unsigned rsp_idle_pct;
   logic        holdoff_go;
   logic        rsp_blocked;
   int unsigned maps_sent;
   int unsigned loads_sent;
   int unsigned bases_used;

   // Table chain built by raw loads: root -> level 3 -> level 2 -> leaf
   logic [39:0] pool_base;
   logic [3:0]  table_page [3];
   logic [3:0]  leaf_page [2];
   logic [8:0]  live_idx [3][4];

   four_level_page_table_mapper_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   pgtm_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_mon     (csr_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Drop response ready at random, or fully during the hold-off
   initial begin : reply_sink
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= !rsp_blocked && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Hold off responses for a long stretch once requested
   initial begin : long_holdoff
      rsp_blocked = 1'b0;
      holdoff_go  = 1'b0;
      wait (holdoff_go === 1'b1);
      @(posedge clock);
      rsp_blocked <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      rsp_blocked <= 1'b0;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d replies outstanding", cycle_count, outstanding);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Present entry with random attribute bits pointing at a frame
   function automatic logic [63:0] pool_entry(input logic [39:0] frame);
      return (rand64() & KEEP_MASK) | {12'b0, frame, 12'b0} | 64'd1;
   endfunction

   function automatic logic [47:0] live_va(input int r0, input int r1, input int r2);
      return {live_idx[0][r0], live_idx[1][r1], live_idx[2][r2], 21'($urandom)};
   endfunction

   // Offer one request after a random gap and hold it until the transfer
   task automatic offer_request(input logic        action,
                                input logic [47:0] va,
                                input logic [51:0] pa,
                                input logic [63:0] flags,
                                input logic [3:0]  page,
                                input logic [8:0]  slot,
                                input logic [63:0] value);
      int unsigned gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.action       <= action;
      req_chan.virt_address <= va;
      req_chan.phys_address <= pa;
      req_chan.map_flags    <= flags;
      req_chan.load_page    <= page;
      req_chan.load_slot    <= slot;
      req_chan.load_value   <= value;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (action == ACTION_MAP) maps_sent++;
      else loads_sent++;
   endtask

   task automatic send_map(input logic [47:0] va, input logic [51:0] pa,
                           input logic [63:0] flags);
      offer_request(ACTION_MAP, va, pa, flags, 4'($urandom), 9'($urandom), rand64());
   endtask

   task automatic send_load(input logic [3:0] page, input logic [8:0] slot,
                            input logic [63:0] value);
      offer_request(ACTION_LOAD, 48'(rand64()), 52'(rand64()), rand64(), page, slot, value);
   endtask

   // Hold requests until every reply has come back
   task automatic drain_replies();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_pool_base(input logic [39:0] frame);
      csr_chan.valid           <= 1'b1;
      csr_chan.pool_base_frame <= frame;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      csr_chan.valid <= 1'b0;
      pool_base = frame;
      bases_used++;
   endtask

   // Point one chain entry at its next table, or break it with an outside frame
   task automatic link_entry(input int level, input int r, input bit intact);
      logic [39:0] rel;
      rel = (level < 2) ? 40'(table_page[level + 1]) : 40'(leaf_page[r % 2]);
      if (!intact) begin
         if ($urandom_range(1) == 0) rel = 40'(POOL_PAGES + $urandom_range(3));
         else rel = 40'(rand64());
         if (rel < 40'(POOL_PAGES)) rel = rel + 40'(POOL_PAGES);
      end
      send_load(table_page[level], live_idx[level][r], pool_entry(pool_base + rel));
   endtask

   // Pick distinct pages for the chain and link four paths through it
   task automatic build_layout();
      logic [15:0] taken;
      logic [3:0]  p;
      int          k, lvl, r;
      taken = 16'h0001;
      for (k = 0; k < 4; k++) begin
         do p = 4'($urandom_range(15, 1)); while (taken[p]);
         taken[p] = 1'b1;
         if (k < 2) table_page[k + 1] = p;
         else leaf_page[k - 2] = p;
      end
      for (lvl = 0; lvl < 3; lvl++) begin
         for (r = 0; r < 4; r++) begin
            live_idx[lvl][r] = 9'($urandom);
            link_entry(lvl, r, 1'b1);
         end
      end
   endtask

   // Random traffic: mostly deep maps, with leaf and stray loads and broken links
   task automatic run_phase(input int unsigned items, input bit pause_midway);
      int unsigned start, pick;
      int          lvl, r;
      logic [3:0]  p;
      bit          paused;
      start  = maps_sent + loads_sent;
      paused = 1'b0;
      while (maps_sent + loads_sent - start < items) begin
         if (pause_midway && !paused && maps_sent + loads_sent - start >= items / 2) begin
            drain_replies();
            paused = 1'b1;
         end
         pick = $urandom_range(99);
         lvl  = $urandom_range(2);
         r    = $urandom_range(3);
         if (pick < 55) begin
            send_map(live_va($urandom_range(3), $urandom_range(3), $urandom_range(3)),
                     52'(rand64()), rand64());
         end else if (pick < 70) begin
            send_load(leaf_page[$urandom_range(1)], 9'($urandom), rand64());
         end else if (pick < 82) begin
            do p = 4'($urandom); while (p == 4'd0 || p == table_page[1] || p == table_page[2]);
            send_load(p, 9'($urandom), rand64());
         end else if (pick < 90) begin
            link_entry(lvl, r, 1'b1);
         end else begin
            link_entry(lvl, r, 1'b0);
            send_map(live_va(r, r, r), 52'(rand64()), rand64());
            link_entry(lvl, r, 1'b1);
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      req_chan.valid           = 1'b0;
      req_chan.action          = ACTION_MAP;
      req_chan.virt_address    = '0;
      req_chan.phys_address    = '0;
      req_chan.map_flags       = '0;
      req_chan.load_page       = '0;
      req_chan.load_slot       = '0;
      req_chan.load_value      = '0;
      csr_chan.valid           = 1'b0;
      csr_chan.pool_base_frame = '0;
      send_idle_pct            = 0;
      rsp_idle_pct             = 0;
      maps_sent                = 0;
      loads_sent               = 0;
      bases_used               = 0;
      table_page[0]            = 4'd0;
      reset                    = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: fresh chains, partial sharing, leaf rewrite, outside entries
      write_pool_base(40'd0);
      send_load(4'd1, 9'd0, 64'd0);
      send_map(48'd0, 52'd0, 64'd0);
      send_map(48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_map(48'd0, 52'(rand64()), 64'hFFFF_FFFF_FFFF_FFFF);
      send_map(48'h0000_4000_0000, 52'(rand64()), rand64());
      send_map(48'h0000_0020_0000, 52'(rand64()), rand64());
      send_load(4'd0, 9'd2, pool_entry(40'd16));
      send_map(48'h0100_0000_0000, 52'(rand64()), rand64());
      send_load(4'd0, 9'd2, 64'hFFFF_FFFF_FFFF_FFFF);
      send_map(48'h0100_0000_1000, 52'(rand64()), rand64());
      send_load(4'd15, 9'd511, 64'hFFFF_FFFF_FFFF_FFFF);
      send_map(48'hFFFF_FFFF_FFFF, 52'd0, 64'd0);
      drain_replies();

      // Random phases under three idling schemes and several pool bases
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase / 2)
            0: begin
               send_idle_pct = 21;
               rsp_idle_pct <= 68;
            end
            1: begin
               send_idle_pct = 68;
               rsp_idle_pct <= 21;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct <= 0;
            end
         endcase
         case (phase)
            0:       write_pool_base(40'hFF_FFFF_FFFF);
            2:       write_pool_base(40'h0);
            3:       write_pool_base(40'hFF_FFFF_FFF8);
            5:       write_pool_base(40'd1);
            default: write_pool_base(40'(rand64()));
         endcase
         build_layout();
         if (phase == 1) holdoff_go <= 1'b1;
         run_phase(ITEMS_PER_PHASE, phase == 3);
         drain_replies();
      end

      // Exhaust the pool from an empty root slot, then probe the halted block
      send_load(4'd0, FRESH_ROOT, 64'd0);
      send_map({FRESH_ROOT, 39'(rand64())}, 52'(rand64()), rand64());
      send_map(live_va(0, 0, 0), 52'(rand64()), rand64());
      send_load(leaf_page[0], 9'($urandom), rand64());
      repeat (4) begin
         if ($urandom_range(1) == 0) send_map(48'(rand64()), 52'(rand64()), rand64());
         else send_load(4'($urandom), 9'($urandom), rand64());
      end
      drain_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d maps and %0d raw loads over %0d pool base settings,",
               maps_sent, loads_sent, bases_used);
      $display("including outside-pool links, pool exhaustion and the halted state.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
